// ----- src/mrf_pkg.sv -----
// shared types, constants and crc function for the modbus rtu request framer
package mrf_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_DATA    = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  COIL_ON  = 8'hFF;
    localparam logic [7:0]  COIL_OFF = 8'h00;

    typedef enum logic [1:0] {
        ACT_HEADER = 2'd0,
        ACT_COIL   = 2'd1,
        ACT_REG    = 2'd2
    } action_t;

    localparam logic [2:0] SEL_RD_COILS    = 3'd0;
    localparam logic [2:0] SEL_RD_DISCRETE = 3'd1;
    localparam logic [2:0] SEL_RD_HOLDING  = 3'd2;
    localparam logic [2:0] SEL_RD_INPUT    = 3'd3;
    localparam logic [2:0] SEL_WR_COIL     = 3'd4;
    localparam logic [2:0] SEL_WR_REG      = 3'd5;
    localparam logic [2:0] SEL_WR_COILS    = 3'd6;
    localparam logic [2:0] SEL_WR_REGS     = 3'd7;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_COILS = 3'b010,
        MODE_REGS  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] bytes;
        logic [2:0]               n_data;
        logic                     fin;
        logic                     init;
    } cmd_t;

    function automatic logic [7:0] func_code(input logic [2:0] sel);
        logic [7:0] code;
        unique case (sel)
            SEL_RD_COILS:    code = 8'h01;
            SEL_RD_DISCRETE: code = 8'h02;
            SEL_RD_HOLDING:  code = 8'h03;
            SEL_RD_INPUT:    code = 8'h04;
            SEL_WR_COIL:     code = 8'h05;
            SEL_WR_REG:      code = 8'h06;
            SEL_WR_COILS:    code = 8'h0F;
            SEL_WR_REGS:     code = 8'h10;
            default:         code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/mrf_front.sv -----
// front end: accepts requests, tracks the open frame and builds byte commands
module mrf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic [7:0]          slave_id,
    input  logic [2:0]          func_sel,
    input  logic [15:0]         start_address,
    input  logic [15:0]         quantity,
    input  logic [15:0]         data_value,
    output logic                push,
    output mrf_pkg::cmd_t       cmd
);

    mrf_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    left_reg, left_next;
    logic [7:0]     acc_reg, acc_next;
    logic [2:0]     pos_reg, pos_next;

    logic [15:0]    left_dec;
    logic [7:0]     acc_set;
    logic           coil_done;
    logic [16:0]    coil_sum;
    logic [7:0]     byte_cnt;

    assign left_dec  = left_reg - 16'd1;
    assign acc_set   = acc_reg | (8'((data_value != 16'd0) ? 1 : 0) << pos_reg);
    assign coil_done = (pos_reg == 3'd7) || (left_dec == 16'd0);
    assign coil_sum  = {1'b0, quantity} + 17'd7;
    assign byte_cnt  = (func_sel == mrf_pkg::SEL_WR_COILS) ? coil_sum[10:3]
                                                           : {quantity[6:0], 1'b0};

    always_comb
    begin
        mode_next = mode_reg;
        left_next = left_reg;
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        push      = 1'b0;
        cmd       = '0;
        if (accept)
        begin
            case (action)
                mrf_pkg::ACT_HEADER:
                begin
                    push          = 1'b1;
                    cmd.init      = 1'b1;
                    cmd.bytes[0]  = slave_id;
                    cmd.bytes[1]  = mrf_pkg::func_code(func_sel);
                    cmd.bytes[2]  = start_address[15:8];
                    cmd.bytes[3]  = start_address[7:0];
                    cmd.n_data    = 3'd6;
                    cmd.fin       = 1'b1;
                    acc_next      = 8'd0;
                    pos_next      = 3'd0;
                    left_next     = 16'd0;
                    mode_next     = mrf_pkg::MODE_IDLE;
                    unique case (func_sel) inside
                        mrf_pkg::SEL_WR_COIL:
                        begin
                            cmd.bytes[4] = (data_value != 16'd0) ? mrf_pkg::COIL_ON
                                                                 : mrf_pkg::COIL_OFF;
                            cmd.bytes[5] = mrf_pkg::COIL_OFF;
                        end
                        mrf_pkg::SEL_WR_REG:
                        begin
                            cmd.bytes[4] = data_value[15:8];
                            cmd.bytes[5] = data_value[7:0];
                        end
                        mrf_pkg::SEL_WR_COILS, mrf_pkg::SEL_WR_REGS:
                        begin
                            cmd.bytes[4] = quantity[15:8];
                            cmd.bytes[5] = quantity[7:0];
                            cmd.bytes[6] = byte_cnt;
                            cmd.n_data   = 3'd7;
                            cmd.fin      = (quantity == 16'd0);
                            left_next    = quantity;
                            if (quantity != 16'd0)
                            begin
                                mode_next = (func_sel == mrf_pkg::SEL_WR_COILS)
                                          ? mrf_pkg::MODE_COILS : mrf_pkg::MODE_REGS;
                            end
                        end
                        default:
                        begin
                            cmd.bytes[4] = quantity[15:8];
                            cmd.bytes[5] = quantity[7:0];
                        end
                    endcase
                end
                mrf_pkg::ACT_COIL:
                begin
                    if (mode_reg == mrf_pkg::MODE_COILS)
                    begin
                        push         = coil_done;
                        cmd.bytes[0] = acc_set;
                        cmd.n_data   = coil_done ? 3'd1 : 3'd0;
                        cmd.fin      = (left_dec == 16'd0);
                        acc_next     = coil_done ? 8'd0 : acc_set;
                        pos_next     = coil_done ? 3'd0 : pos_reg + 3'd1;
                        left_next    = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            mode_next = mrf_pkg::MODE_IDLE;
                        end
                    end
                end
                mrf_pkg::ACT_REG:
                begin
                    if (mode_reg == mrf_pkg::MODE_REGS)
                    begin
                        push         = 1'b1;
                        cmd.bytes[0] = data_value[15:8];
                        cmd.bytes[1] = data_value[7:0];
                        cmd.n_data   = 3'd2;
                        cmd.fin      = (left_dec == 16'd0);
                        left_next    = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            mode_next = mrf_pkg::MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mrf_pkg::MODE_IDLE;
            left_reg <= 16'd0;
            acc_reg  <= 8'd0;
            pos_reg  <= 3'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ----- src/mrf_queue.sv -----
// command queue between front end and byte serializer
module mrf_queue
#(
    parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mrf_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrf_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/mrf_back.sv -----
// back end: sends command bytes one per cycle unless out_stall holds them, keeps the running crc and appends it
module mrf_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  mrf_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic          out_stall,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_end
);

    logic          cur_valid_reg, cur_valid_next;
    mrf_pkg::cmd_t cur_reg;
    logic [3:0]    idx_reg, idx_next;
    logic [15:0]   crc_reg, crc_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic          end_reg;

    logic [3:0]    total;
    logic          last;
    logic          in_data;
    logic          crc_lo;
    logic [7:0]    byte_sel;
    logic          advance;
    logic          load;

    assign total    = {1'b0, cur_reg.n_data} + (cur_reg.fin ? 4'd2 : 4'd0);
    assign last     = (idx_reg == total - 4'd1);
    assign in_data  = (idx_reg < {1'b0, cur_reg.n_data});
    assign crc_lo   = (idx_reg == {1'b0, cur_reg.n_data});
    assign byte_sel = in_data ? cur_reg.bytes[idx_reg[2:0]]
                    : (crc_lo ? crc_reg[7:0] : crc_reg[15:8]);
    assign advance  = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign load     = q_valid && (!cur_valid_reg || (advance && last));
    assign q_pop    = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        if (advance)
        begin
            idx_next = idx_reg + 4'd1;
            if (in_data)
            begin
                crc_next = mrf_pkg::crc_byte(crc_reg, byte_sel);
            end
            else if (!crc_lo)
            begin
                crc_next = mrf_pkg::CRC_INIT;
            end
            if (last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 4'd0;
            if (q_cmd.init)
            begin
                crc_next = mrf_pkg::CRC_INIT;
            end
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            crc_reg       <= mrf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_cmd;
        end
        if (advance)
        begin
            byte_reg <= byte_sel;
            last_reg <= last;
            end_reg  <= !in_data && !crc_lo;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_end   = end_reg;

endmodule

// ----- src/modbus_rtu_request_framer_core.sv -----
// top level of the modbus rtu request framer: front end, command queue, byte serializer
// Turns requests into a Modbus RTU master frame byte stream with the CRC-16 appended low
// byte first. A header request yields 8 bytes (read or single write) or 7 bytes (multiple
// write, 9 when the count is zero); a register word yields 2 bytes, plus 2 CRC bytes on the
// last element; a coil bit yields a byte every eighth bit or on the last coil, plus the CRC.
// The serializer sends one byte per cycle while byte_stall is low, and a request yields
// 0 to 9 bytes. Requests are taken every cycle while the command queue (QUEUE_DEPTH
// entries) has room, and a header may abandon an open frame at any time.
module modbus_rtu_request_framer_core
#(
    parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  slave_id,
    input  logic [2:0]  func_sel,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    input  logic [15:0] data_value,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  frame_byte,
    output logic        run_last,
    output logic        frame_end
);

    logic          accept;
    logic          q_push;
    mrf_pkg::cmd_t q_push_cmd;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    mrf_pkg::cmd_t q_head;

    assign accept     = item_valid && !item_stall;
    assign item_stall = q_full;

    mrf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .action        (action),
        .slave_id      (slave_id),
        .func_sel      (func_sel),
        .start_address (start_address),
        .quantity      (quantity),
        .data_value    (data_value),
        .push          (q_push),
        .cmd           (q_push_cmd)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    mrf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .out_stall (byte_stall),
        .out_valid (byte_valid),
        .out_byte  (frame_byte),
        .out_last  (run_last),
        .out_end   (frame_end)
    );

    // crc high byte always closes the request that caused it
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && frame_end) |-> run_last)
        else $error("frame end without run last");

    // crc low byte always sits between two frame ends
    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && frame_end) |=> !(byte_valid && frame_end))
        else $error("two frame ends in a row");

    // a queued command is never lost to a push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_full) |-> !accept)
        else $error("push into full queue");

endmodule

// ----- test/request_frame_checker.sv -----
// checker for the modbus rtu request framer: predicts the frame byte stream and compares it
`timescale 1ns / 1ps

module request_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  slave_id,
    input  logic [2:0]  func_sel,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    input  logic [15:0] data_value,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  frame_byte,
    input  logic        run_last,
    input  logic        frame_end,
    output int          mismatch_count,
    output int          bytes_due
);
    import mrf_pkg::*;

    // function codes indexed by func_sel
    localparam logic [7:0][7:0] FUNC_CODES =
        {8'h10, 8'h0F, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01};

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       frame_done;
    } wire_byte_t;

    wire_byte_t  frame_bytes_due[$];
    wire_byte_t  oldest;
    int          errors = 0;
    int          due_count = 0;

    logic [15:0] crc;
    logic [7:0]  coil_acc;
    logic [2:0]  coil_pos;
    logic [15:0] elems_left;
    mode_t       frame_state;

    logic [7:0]  req_bytes[0:8];
    logic        req_ends[0:8];
    int          req_count;

    assign mismatch_count = errors;
    assign bytes_due      = due_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch, %s", $time, msg);
        errors++;
    endtask

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0];
            r  = {1'b0, r[15:1]};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic clear_frame();
        crc         = CRC_INIT;
        coil_acc    = 8'h00;
        coil_pos    = 3'd0;
        elems_left  = 16'd0;
        frame_state = MODE_IDLE;
    endtask

    task automatic put_byte(input logic [7:0] b, input logic ends);
        req_bytes[req_count] = b;
        req_ends[req_count]  = ends;
        req_count++;
    endtask

    task automatic add_data(input logic [7:0] b);
        crc = crc16_step(crc, b);
        put_byte(b, 1'b0);
    endtask

    task automatic close_frame();
        logic [15:0] c;
        c = crc;
        put_byte(c[7:0], 1'b0);
        put_byte(c[15:8], 1'b1);
        clear_frame();
    endtask

    task automatic predict_request(input logic [1:0] act, input logic [7:0] sid,
                                   input logic [2:0] sel, input logic [15:0] addr,
                                   input logic [15:0] qty, input logic [15:0] val);
        logic [16:0] coil_bytes;
        logic [7:0]  byte_count;
        wire_byte_t  wb;
        req_count = 0;
        if (act == ACT_HEADER)
        begin
            clear_frame();
            add_data(sid);
            add_data(FUNC_CODES[sel]);
            add_data(addr[15:8]);
            add_data(addr[7:0]);
            if (sel == SEL_WR_COIL)
            begin
                add_data((val != 16'd0) ? COIL_ON : COIL_OFF);
                add_data(8'h00);
                close_frame();
            end
            else if (sel == SEL_WR_REG)
            begin
                add_data(val[15:8]);
                add_data(val[7:0]);
                close_frame();
            end
            else
            begin
                add_data(qty[15:8]);
                add_data(qty[7:0]);
                if (sel == SEL_WR_COILS || sel == SEL_WR_REGS)
                begin
                    coil_bytes = {1'b0, qty} + 17'd7;
                    byte_count = (sel == SEL_WR_COILS) ? coil_bytes[10:3] : {qty[6:0], 1'b0};
                    add_data(byte_count);
                    elems_left = qty;
                    if (qty == 16'd0)
                    begin
                        close_frame();
                    end
                    else
                    begin
                        frame_state = (sel == SEL_WR_COILS) ? MODE_COILS : MODE_REGS;
                    end
                end
                else
                begin
                    close_frame();
                end
            end
        end
        else if (act == ACT_COIL && frame_state == MODE_COILS)
        begin
            if (val != 16'd0)
            begin
                coil_acc[coil_pos] = 1'b1;
            end
            elems_left = elems_left - 16'd1;
            if (coil_pos == 3'd7 || elems_left == 16'd0)
            begin
                add_data(coil_acc);
                coil_acc = 8'h00;
                coil_pos = 3'd0;
            end
            else
            begin
                coil_pos = coil_pos + 3'd1;
            end
            if (elems_left == 16'd0)
            begin
                close_frame();
            end
        end
        else if (act == ACT_REG && frame_state == MODE_REGS)
        begin
            add_data(val[15:8]);
            add_data(val[7:0]);
            elems_left = elems_left - 16'd1;
            if (elems_left == 16'd0)
            begin
                close_frame();
            end
        end
        for (int i = 0; i < req_count; i++)
        begin
            wb.value      = req_bytes[i];
            wb.run_end    = (i == req_count - 1);
            wb.frame_done = req_ends[i];
            frame_bytes_due.push_back(wb);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            frame_bytes_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_request(action, slave_id, func_sel, start_address, quantity, data_value);
            end
            if (byte_valid && !byte_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h with nothing due", frame_byte));
                end
                else
                begin
                    oldest = frame_bytes_due.pop_front();
                    if (frame_byte !== oldest.value)
                    begin
                        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                  frame_byte, oldest.value));
                    end
                    if (run_last !== oldest.run_end)
                    begin
                        report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                                  run_last, oldest.run_end, oldest.value));
                    end
                    if (frame_end !== oldest.frame_done)
                    begin
                        report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                                  frame_end, oldest.frame_done, oldest.value));
                    end
                end
            end
            due_count <= frame_bytes_due.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// top of the modbus rtu request framer testbench: clock, reset, requests and verdict
`timescale 1ns / 1ps

module testbench;
    import mrf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  action = ACT_HEADER;
    logic [7:0]  slave_id = 8'h00;
    logic [2:0]  func_sel = 3'd0;
    logic [15:0] start_address = 16'h0000;
    logic [15:0] quantity = 16'h0000;
    logic [15:0] data_value = 16'h0000;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        run_last;
    logic        frame_end;

    int          mismatch_count;
    int          bytes_due;
    int          burst_left = 0;
    int          useful = 0;
    int          stall_style = 0;
    logic [6:0]  stall_span = 7'd0;

    modbus_rtu_request_framer_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .slave_id      (slave_id),
        .func_sel      (func_sel),
        .start_address (start_address),
        .quantity      (quantity),
        .data_value    (data_value),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .frame_byte    (frame_byte),
        .run_last      (run_last),
        .frame_end     (frame_end)
    );

    request_frame_checker frame_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .slave_id       (slave_id),
        .func_sel       (func_sel),
        .start_address  (start_address),
        .quantity       (quantity),
        .data_value     (data_value),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .frame_byte     (frame_byte),
        .run_last       (run_last),
        .frame_end      (frame_end),
        .mismatch_count (mismatch_count),
        .bytes_due      (bytes_due)
    );

    always #10 clk = ~clk;

    // receiver back-pressure, style picked anew at random whenever the span counter runs out
    always @(posedge clk)
    begin
        if (stall_span == 7'd0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_span  <= 7'($urandom_range(16, 96));
        end
        else
        begin
            stall_span <= stall_span - 7'd1;
        end
        case (stall_style)
            0:       byte_stall <= 1'b0;
            1:       byte_stall <= ($urandom_range(0, 1) == 0);
            2:       byte_stall <= ($urandom_range(0, 9) < 8);
            default: byte_stall <= (stall_span[2:0] < 3'd3);
        endcase
    end

    task automatic send_request(input logic [1:0] act, input logic [7:0] sid,
                                input logic [2:0] sel, input logic [15:0] addr,
                                input logic [15:0] qty, input logic [15:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 7);
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid    <= 1'b1;
        action        <= act;
        slave_id      <= sid;
        func_sel      <= sel;
        start_address <= addr;
        quantity      <= qty;
        data_value    <= val;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return 16'h0000;
        end
        else if (r < 5)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // request the block should ignore: wrong data kind or unused action code
    task automatic send_noise(input logic [1:0] wrong_act);
        logic [1:0] act;
        act = ($urandom_range(0, 1) == 0) ? ACT_UNUSED : wrong_act;
        send_request(act, 8'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                     rand_value());
    endtask

    task automatic random_frame();
        logic [2:0]  sel;
        logic [15:0] qty;
        logic [1:0]  data_act;
        int          n_el;
        int          r;
        sel = 3'($urandom);
        r   = $urandom_range(0, 99);
        qty = 16'($urandom);
        if (sel == SEL_WR_COILS && r < 80)
        begin
            qty = (r < 8) ? 16'd0 : 16'($urandom_range(1, 24));
        end
        else if (sel == SEL_WR_REGS && r < 80)
        begin
            qty = (r < 8) ? 16'd0 : 16'($urandom_range(1, 6));
        end
        send_request(ACT_HEADER, 8'($urandom), sel, 16'($urandom), qty, rand_value());
        useful++;
        if (sel == SEL_WR_COILS || sel == SEL_WR_REGS)
        begin
            data_act = (sel == SEL_WR_COILS) ? ACT_COIL : ACT_REG;
            n_el = (qty > 16'd40) ? $urandom_range(0, 3) : int'(qty);
            if ($urandom_range(0, 9) == 0 && n_el > 0)
            begin
                n_el = $urandom_range(0, n_el - 1);
            end
            for (int i = 0; i < n_el; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_noise((sel == SEL_WR_COILS) ? ACT_REG : ACT_COIL);
                end
                send_request(data_act, 8'($urandom), 3'($urandom), 16'($urandom),
                             16'($urandom), rand_value());
                useful++;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every function, the special cases
        send_request(ACT_HEADER, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_HEADER, 8'hFF, SEL_RD_DISCRETE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(ACT_HEADER, 8'h11, SEL_RD_HOLDING, 16'h006B, 16'h0003, 16'h0000);
        send_request(ACT_HEADER, 8'hA5, SEL_RD_INPUT, 16'h5A5A, 16'hA5A5, 16'h1234);
        send_request(ACT_HEADER, 8'h01, SEL_WR_COIL, 16'h00AC, 16'h0000, 16'h0000);
        send_request(ACT_HEADER, 8'h02, SEL_WR_COIL, 16'h00AD, 16'h0000, 16'h0001);
        send_request(ACT_HEADER, 8'h7F, SEL_WR_REG, 16'h8000, 16'h0000, 16'hFFFF);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(ACT_UNUSED, 8'hFF, SEL_WR_REGS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(ACT_HEADER, 8'h03, SEL_WR_COILS, 16'h0013, 16'h0000, 16'h0000);
        send_request(ACT_HEADER, 8'h04, SEL_WR_REGS, 16'h0001, 16'h0000, 16'h0000);
        send_request(ACT_HEADER, 8'h05, SEL_WR_COILS, 16'h0013, 16'h0009, 16'h0000);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0001);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h8000);
        send_request(ACT_REG, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'hBEEF);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h00FF);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0002);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0001);
        send_request(ACT_HEADER, 8'h06, SEL_WR_REGS, 16'h0100, 16'h0080, 16'h0000);
        send_request(ACT_REG, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(ACT_HEADER, 8'h07, SEL_WR_COILS, 16'h0200, 16'hFFFF, 16'h0000);
        send_request(ACT_COIL, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0001);
        send_request(ACT_HEADER, 8'h08, SEL_WR_REGS, 16'h0300, 16'h0002, 16'h0000);
        send_request(ACT_REG, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_REG, 8'h00, SEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF);
        drain();

        while (useful < 75)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_noise(($urandom_range(0, 1) == 0) ? ACT_COIL : ACT_REG);
            end
            random_frame();
            if ($urandom_range(0, 14) == 0)
            begin
                drain();
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
